>>> rtl/tsnm_pkg.sv
package tsnm_pkg;

	localparam int COMP_W = 16;
	localparam int VEC_W  = 3 * COMP_W;

	typedef logic signed [COMP_W-1:0] comp_t;

	// one input beat
	typedef struct packed {
		logic [VEC_W-1:0] normal_vec;
		logic [VEC_W-1:0] tangent_vec;
		logic [VEC_W-1:0] bitangent_vec;
		logic [VEC_W-1:0] map_sample_vec;
		logic             apply;
	} in_beat_t;

	// one result beat
	typedef struct packed {
		comp_t out_x;
		comp_t out_y;
		comp_t out_z;
		logic  degenerate;
	} out_beat_t;

	// control flags that ride along with the data
	typedef struct packed {
		logic apply;
		logic degen;
	} flags_t;

	// component k of a packed vector, x in the low bits
	function automatic comp_t comp_of(input logic [VEC_W-1:0] v, input int unsigned k);
		return comp_t'(v[k*COMP_W +: COMP_W]);
	endfunction

	// v / 2^s rounded to nearest, halves away from zero
	function automatic logic signed [63:0] rshift(input logic signed [63:0] v,
	                                              input int unsigned s);
		logic [63:0] mag;
		logic [63:0] r;
		mag = v[63] ? 64'(-v) : 64'(v);
		r = (mag + (64'd1 << (s - 1))) >> s;
		return v[63] ? -$signed(r) : $signed(r);
	endfunction

	// clamp to [-1.0, 1.0] with f fraction bits
	function automatic logic signed [63:0] sat_one(input logic signed [63:0] v,
	                                               input int unsigned f);
		logic signed [63:0] one;
		one = 64'sd1 <<< f;
		if (v > one) begin
			return one;
		end
		if (v < -one) begin
			return -one;
		end
		return v;
	endfunction

endpackage

>>> rtl/tsnm_if.sv
interface tsnm_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/tangent_space_normal_map_top.sv
// Tangent-space normal map perturbation.
// Input channel "item" carries the normal, tangent, bitangent and map sample
// (three signed components each, x in the low 16 bits) and the apply flag.
// Output channel "result" carries the unit normal out_x/out_y/out_z with
// FRAC_BITS fraction bits and the degenerate flag.
// Both channels are valid/ready; a beat moves when both are high.
// One beat is accepted per cycle unless a stalled receiver freezes the
// pipeline. TN_W and R_W are the widths of the two length square roots; the
// two digit-by-digit square roots and the two restoring dividers set the
// pipeline depth. All stages share one advance enable: when the result
// register is full and the receiver is stalled, the pipeline freezes once
// its last stage holds a beat, and item.ready drops; bubbles keep draining
// meanwhile.
// Reset clears all valid bits; there is no other state and no warm-up.
module tangent_space_normal_map_top #(
	parameter int FRAC_BITS = 14
) (
	input  logic   clk,
	input  logic   arst_n,
	tsnm_if.sink   item,
	tsnm_if.source result
);
	import tsnm_pkg::*;

	localparam int F     = FRAC_BITS;
	localparam int D_W   = 34;
	localparam int P_W   = 50;
	localparam int TN_W  = (52 - 2 * F > 17) ? 52 - 2 * F : 17;
	localparam int SQ1_W = 2 * TN_W;
	localparam int Q_W   = F + 2;
	localparam int CP_W  = COMP_W + Q_W;
	localparam int NB_W  = 18;
	localparam int BP_W  = NB_W + COMP_W;
	localparam int PR_W  = ((Q_W > NB_W) ? Q_W : NB_W) + COMP_W;
	localparam int SR_W  = PR_W + 2;
	localparam int R_W   = SR_W - F + 1;
	localparam int SQ2_W = 2 * R_W;
	localparam int SB1_W = 3 * VEC_W + 3 * TN_W + 1;
	localparam int SB2_W = 3 * VEC_W + 2;
	localparam int SB3_W = VEC_W + 3 * R_W + 2;
	localparam int SB4_W = VEC_W + 2;
	localparam logic signed [Q_W-1:0] ONE_Q = Q_W'(1 << F);

	logic adv;
	logic hold;

	// front stages
	logic                   v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [VEC_W-1:0]       n_s1, t_s1, b_s1, m_s1;
	logic                   ap_s1;
	logic signed [D_W-1:0]  d_s2;
	logic [VEC_W-1:0]       n_s2, t_s2, b_s2, m_s2;
	logic                   ap_s2;
	logic signed [P_W-1:0]  p_s3 [3];
	logic [VEC_W-1:0]       n_s3, t_s3, b_s3, m_s3;
	logic                   ap_s3;
	logic [2:0][TN_W-1:0]   tn_s4;
	logic [VEC_W-1:0]       n_s4, b_s4, m_s4;
	logic                   ap_s4;
	logic [SQ1_W-1:0]       sq_s5 [3];
	logic [2:0][TN_W-1:0]   tn_s5;
	logic [VEC_W-1:0]       n_s5, b_s5, m_s5;
	logic                   ap_s5;

	// first root and divide
	logic                   q1_valid;
	logic [TN_W-1:0]        q1_len;
	logic [SB1_W-1:0]       q1_sb;
	logic [VEC_W-1:0]       q1_n, q1_b, q1_m;
	logic [2:0][TN_W-1:0]   q1_tn;
	logic                   q1_ap;
	flags_t                 fl1;
	logic                   d1_valid;
	logic [2:0][Q_W-1:0]    d1_quo;
	logic [SB2_W-1:0]       d1_sb;
	logic [VEC_W-1:0]       d1_n, d1_b, d1_m;
	flags_t                 d1_fl;

	// middle stages
	logic                   v_s7, v_s8, v_s9, v_s10, v_s11, v_s12, v_s13;
	logic signed [CP_W-1:0] cp_s7 [6];
	logic [2:0][Q_W-1:0]    tq_s7, tq_s8, tq_s9, tq_s10;
	logic [VEC_W-1:0]       n_s7, b_s7, m_s7, n_s8, b_s8, m_s8, n_s9, m_s9, n_s10, m_s10;
	logic [VEC_W-1:0]       n_s11, n_s12, n_s13;
	flags_t                 fl_s7, fl_s8, fl_s9, fl_s10, fl_s11, fl_s12, fl_s13;
	logic signed [NB_W-1:0] nb_s8 [3];
	logic signed [NB_W-1:0] nb_s9 [3];
	logic signed [BP_W-1:0] bp_s9 [3];
	logic signed [NB_W-1:0] nbf_s10 [3];
	logic signed [63:0]     bsum;
	logic signed [PR_W-1:0] rp_s11 [3][3];
	logic [2:0][R_W-1:0]    r_s12, r_s13;
	logic [SQ2_W-1:0]       rq_s13 [3];

	// second root and divide
	logic                   q2_valid;
	logic [R_W-1:0]         q2_len;
	logic [SB3_W-1:0]       q2_sb;
	logic [VEC_W-1:0]       q2_n;
	logic [2:0][R_W-1:0]    q2_r;
	flags_t                 q2_fl;
	flags_t                 fl2;
	logic                   d2_valid;
	logic [2:0][Q_W-1:0]    d2_quo;
	logic [SB4_W-1:0]       d2_sb;
	logic [VEC_W-1:0]       d2_n;
	flags_t                 d2_fl;

	// output register
	logic                   out_valid_q;
	out_beat_t              res_q;
	out_beat_t              res_next;
	logic                   use_map;

	// advance unless the result is stalled and the last stage is full
	assign hold        = out_valid_q & ~result.ready;
	assign adv         = ~(hold & d2_valid);
	assign item.ready  = adv;
	assign result.valid = out_valid_q;
	assign result.data  = res_q;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
			v_s13 <= 1'b0;
		end else if (adv) begin
			v_s1  <= item.valid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s7  <= d1_valid;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
			v_s12 <= v_s11;
			v_s13 <= v_s12;
		end
	end

	// tangent orthogonalization and squared length
	always_ff @(posedge clk) begin
		if (adv) begin
			n_s1  <= item.data.normal_vec;
			t_s1  <= item.data.tangent_vec;
			b_s1  <= item.data.bitangent_vec;
			m_s1  <= item.data.map_sample_vec;
			ap_s1 <= item.data.apply;

			d_s2 <= D_W'(comp_of(t_s1, 0)) * D_W'(comp_of(n_s1, 0))
			      + D_W'(comp_of(t_s1, 1)) * D_W'(comp_of(n_s1, 1))
			      + D_W'(comp_of(t_s1, 2)) * D_W'(comp_of(n_s1, 2));
			n_s2  <= n_s1;
			t_s2  <= t_s1;
			b_s2  <= b_s1;
			m_s2  <= m_s1;
			ap_s2 <= ap_s1;

			for (int k = 0; k < 3; k++) begin
				p_s3[k] <= P_W'(comp_of(n_s2, k)) * P_W'(d_s2);
			end
			n_s3  <= n_s2;
			t_s3  <= t_s2;
			b_s3  <= b_s2;
			m_s3  <= m_s2;
			ap_s3 <= ap_s2;

			for (int k = 0; k < 3; k++) begin
				tn_s4[k] <= TN_W'(64'(comp_of(t_s3, k)) - rshift(64'(p_s3[k]), 2 * F));
			end
			n_s4  <= n_s3;
			b_s4  <= b_s3;
			m_s4  <= m_s3;
			ap_s4 <= ap_s3;

			for (int k = 0; k < 3; k++) begin
				sq_s5[k] <= SQ1_W'($signed(tn_s4[k])) * SQ1_W'($signed(tn_s4[k]));
			end
			tn_s5 <= tn_s4;
			n_s5  <= n_s4;
			b_s5  <= b_s4;
			m_s5  <= m_s4;
			ap_s5 <= ap_s4;
		end
	end

	tsnm_sqrt #(
		.IN_W (SQ1_W),
		.SB_W (SB1_W)
	) u_sqrt_t (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v_s5),
		.x         (sq_s5[0] + sq_s5[1] + sq_s5[2]),
		.in_sb     ({n_s5, b_s5, m_s5, tn_s5, ap_s5}),
		.out_valid (q1_valid),
		.root      (q1_len),
		.out_sb    (q1_sb)
	);

	assign {q1_n, q1_b, q1_m, q1_tn, q1_ap} = q1_sb;
	assign fl1.apply = q1_ap;
	assign fl1.degen = (q1_len == '0);

	// normalize the tangent
	tsnm_div #(
		.V_W  (TN_W),
		.D_W  (TN_W),
		.FRAC (F),
		.SB_W (SB2_W)
	) u_div_t (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (q1_valid),
		.num       (q1_tn),
		.den       (fl1.degen ? TN_W'(1) : q1_len),
		.in_sb     ({q1_n, q1_b, q1_m, fl1}),
		.out_valid (d1_valid),
		.quo       (d1_quo),
		.out_sb    (d1_sb)
	);

	assign {d1_n, d1_b, d1_m, d1_fl} = d1_sb;

	// handedness of the new bitangent
	always_comb begin
		bsum = 64'(bp_s9[0]) + 64'(bp_s9[1]) + 64'(bp_s9[2]);
	end

	// bitangent, frame combination and squared length
	always_ff @(posedge clk) begin
		if (adv) begin
			cp_s7[0] <= CP_W'(comp_of(d1_n, 1)) * CP_W'($signed(d1_quo[2]));
			cp_s7[1] <= CP_W'(comp_of(d1_n, 2)) * CP_W'($signed(d1_quo[1]));
			cp_s7[2] <= CP_W'(comp_of(d1_n, 2)) * CP_W'($signed(d1_quo[0]));
			cp_s7[3] <= CP_W'(comp_of(d1_n, 0)) * CP_W'($signed(d1_quo[2]));
			cp_s7[4] <= CP_W'(comp_of(d1_n, 0)) * CP_W'($signed(d1_quo[1]));
			cp_s7[5] <= CP_W'(comp_of(d1_n, 1)) * CP_W'($signed(d1_quo[0]));
			tq_s7 <= d1_quo;
			n_s7  <= d1_n;
			b_s7  <= d1_b;
			m_s7  <= d1_m;
			fl_s7 <= d1_fl;

			for (int k = 0; k < 3; k++) begin
				nb_s8[k] <= NB_W'(rshift(64'(cp_s7[2*k]) - 64'(cp_s7[2*k+1]), F));
			end
			tq_s8 <= tq_s7;
			n_s8  <= n_s7;
			b_s8  <= b_s7;
			m_s8  <= m_s7;
			fl_s8 <= fl_s7;

			for (int k = 0; k < 3; k++) begin
				bp_s9[k] <= BP_W'(nb_s8[k]) * BP_W'(comp_of(b_s8, k));
				nb_s9[k] <= nb_s8[k];
			end
			tq_s9 <= tq_s8;
			n_s9  <= n_s8;
			m_s9  <= m_s8;
			fl_s9 <= fl_s8;

			for (int k = 0; k < 3; k++) begin
				nbf_s10[k] <= bsum[63] ? NB_W'(-nb_s9[k]) : nb_s9[k];
			end
			tq_s10 <= tq_s9;
			n_s10  <= n_s9;
			m_s10  <= m_s9;
			fl_s10 <= fl_s9;

			for (int k = 0; k < 3; k++) begin
				rp_s11[k][0] <= PR_W'($signed(tq_s10[k])) * PR_W'(comp_of(m_s10, 0));
				rp_s11[k][1] <= PR_W'(nbf_s10[k]) * PR_W'(comp_of(m_s10, 1));
				rp_s11[k][2] <= PR_W'(comp_of(n_s10, k)) * PR_W'(comp_of(m_s10, 2));
			end
			n_s11  <= n_s10;
			fl_s11 <= fl_s10;

			for (int k = 0; k < 3; k++) begin
				r_s12[k] <= R_W'(rshift(64'(rp_s11[k][0]) + 64'(rp_s11[k][1])
				                        + 64'(rp_s11[k][2]), F));
			end
			n_s12  <= n_s11;
			fl_s12 <= fl_s11;

			for (int k = 0; k < 3; k++) begin
				rq_s13[k] <= SQ2_W'($signed(r_s12[k])) * SQ2_W'($signed(r_s12[k]));
			end
			r_s13  <= r_s12;
			n_s13  <= n_s12;
			fl_s13 <= fl_s12;
		end
	end

	tsnm_sqrt #(
		.IN_W (SQ2_W),
		.SB_W (SB3_W)
	) u_sqrt_r (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v_s13),
		.x         (rq_s13[0] + rq_s13[1] + rq_s13[2]),
		.in_sb     ({n_s13, r_s13, fl_s13}),
		.out_valid (q2_valid),
		.root      (q2_len),
		.out_sb    (q2_sb)
	);

	assign {q2_n, q2_r, q2_fl} = q2_sb;
	assign fl2.apply = q2_fl.apply;
	assign fl2.degen = q2_fl.degen | (q2_len == '0);

	// normalize the result
	tsnm_div #(
		.V_W  (R_W),
		.D_W  (R_W),
		.FRAC (F),
		.SB_W (SB4_W)
	) u_div_r (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (q2_valid),
		.num       (q2_r),
		.den       ((q2_len == '0) ? R_W'(1) : q2_len),
		.in_sb     ({q2_n, fl2}),
		.out_valid (d2_valid),
		.quo       (d2_quo),
		.out_sb    (d2_sb)
	);

	assign {d2_n, d2_fl} = d2_sb;

	// pick perturbed or pass-through normal, clamp to unit range
	assign use_map = d2_fl.apply & ~d2_fl.degen;

	always_comb begin
		res_next.out_x = comp_t'(use_map ? sat_one(64'($signed(d2_quo[0])), F)
		                                 : sat_one(64'(comp_of(d2_n, 0)), F));
		res_next.out_y = comp_t'(use_map ? sat_one(64'($signed(d2_quo[1])), F)
		                                 : sat_one(64'(comp_of(d2_n, 1)), F));
		res_next.out_z = comp_t'(use_map ? sat_one(64'($signed(d2_quo[2])), F)
		                                 : sat_one(64'(comp_of(d2_n, 2)), F));
		res_next.degenerate = d2_fl.apply & d2_fl.degen;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!hold) begin
			out_valid_q <= d2_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!hold && d2_valid) begin
			res_q <= res_next;
		end
	end

	// a stalled first stage keeps its beat
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !adv |=> v_s1)
		else $error("first stage lost a beat during a stall");

	// a result only appears from a full last stage
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(d2_valid))
		else $error("result valid without a beat in the last stage");

	// normalized tangent stays within unit range
	a_tan_unit: assert property (@(posedge clk) disable iff (!arst_n)
		d1_valid && !d1_fl.degen |->
			$signed(d1_quo[0]) <= ONE_Q && $signed(d1_quo[0]) >= -ONE_Q &&
			$signed(d1_quo[1]) <= ONE_Q && $signed(d1_quo[1]) >= -ONE_Q &&
			$signed(d1_quo[2]) <= ONE_Q && $signed(d1_quo[2]) >= -ONE_Q)
		else $error("normalized tangent out of range");

	// normalized result stays within unit range
	a_res_unit: assert property (@(posedge clk) disable iff (!arst_n)
		d2_valid && !d2_fl.degen |->
			$signed(d2_quo[0]) <= ONE_Q && $signed(d2_quo[0]) >= -ONE_Q &&
			$signed(d2_quo[1]) <= ONE_Q && $signed(d2_quo[1]) >= -ONE_Q &&
			$signed(d2_quo[2]) <= ONE_Q && $signed(d2_quo[2]) >= -ONE_Q)
		else $error("normalized result out of range");

endmodule

>>> rtl/tsnm_sqrt.sv
module tsnm_sqrt #(
	parameter int IN_W = 48,
	parameter int SB_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [IN_W-1:0]   x,
	input  logic [SB_W-1:0]   in_sb,
	output logic              out_valid,
	output logic [IN_W/2-1:0] root,
	output logic [SB_W-1:0]   out_sb
);
	localparam int H    = IN_W / 2;
	localparam int RM_W = H + 2;

	logic            v_s  [H+1];
	logic [IN_W-1:0] x_s  [H+1];
	logic [RM_W-1:0] rm_s [H+1];
	logic [H-1:0]    rt_s [H+1];
	logic [SB_W-1:0] sb_s [H+1];

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]  <= x;
			rm_s[0] <= '0;
			rt_s[0] <= '0;
			sb_s[0] <= in_sb;
		end
	end

	// one root bit per stage
	for (genvar i = 0; i < H; i++) begin : g_step
		logic [RM_W+1:0] cur;
		logic [RM_W+1:0] trial;
		logic            ge;

		assign cur   = {rm_s[i], x_s[i][IN_W-1 -: 2]};
		assign trial = (RM_W + 2)'({rt_s[i], 2'b01});
		assign ge    = (cur >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[i+1]  <= x_s[i] << 2;
				rm_s[i+1] <= ge ? RM_W'(cur - trial) : RM_W'(cur);
				rt_s[i+1] <= {rt_s[i][H-2:0], ge};
				sb_s[i+1] <= sb_s[i];
			end
		end
	end

	assign out_valid = v_s[H];
	assign root      = rt_s[H];
	assign out_sb    = sb_s[H];

endmodule

>>> rtl/tsnm_div.sv
module tsnm_div #(
	parameter int V_W  = 24,
	parameter int D_W  = 24,
	parameter int FRAC = 14,
	parameter int SB_W = 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_valid,
	input  logic [2:0][V_W-1:0]   num,
	input  logic [D_W-1:0]        den,
	input  logic [SB_W-1:0]       in_sb,
	output logic                  out_valid,
	output logic [2:0][FRAC+1:0]  quo,
	output logic [SB_W-1:0]       out_sb
);
	localparam int QB  = FRAC + 1;
	localparam int N_W = V_W + FRAC + 1;
	localparam int R_W = D_W + 1;

	logic                v_s  [QB+1];
	logic [2:0][R_W-1:0] rm_s [QB+1];
	logic [2:0][QB-1:0]  lo_s [QB+1];
	logic [2:0][QB-1:0]  q_s  [QB+1];
	logic [2:0]          sg_s [QB+1];
	logic [D_W-1:0]      dn_s [QB+1];
	logic [SB_W-1:0]     sb_s [QB+1];

	logic [2:0][V_W-1:0] mag;
	logic [2:0][N_W-1:0] nn;

	// magnitude scaled by 2^FRAC, plus half the divisor
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			mag[k] = num[k][V_W-1] ? V_W'(-num[k]) : num[k];
			nn[k]  = (N_W'(mag[k]) << FRAC) + N_W'(den >> 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				rm_s[0][k] <= R_W'(nn[k] >> QB);
				lo_s[0][k] <= nn[k][QB-1:0];
				q_s[0][k]  <= '0;
				sg_s[0][k] <= num[k][V_W-1];
			end
			dn_s[0] <= den;
			sb_s[0] <= in_sb;
		end
	end

	// restoring division, one quotient bit per stage
	for (genvar i = 0; i < QB; i++) begin : g_step
		logic [2:0][R_W-1:0] trial;
		logic [2:0]          ge;

		always_comb begin
			for (int k = 0; k < 3; k++) begin
				trial[k] = {rm_s[i][k][R_W-2:0], lo_s[i][k][QB-1]};
				ge[k]    = (trial[k] >= {1'b0, dn_s[i]});
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int k = 0; k < 3; k++) begin
					rm_s[i+1][k] <= ge[k] ? R_W'(trial[k] - {1'b0, dn_s[i]}) : trial[k];
					lo_s[i+1][k] <= lo_s[i][k] << 1;
					q_s[i+1][k]  <= {q_s[i][k][QB-2:0], ge[k]};
				end
				sg_s[i+1] <= sg_s[i];
				dn_s[i+1] <= dn_s[i];
				sb_s[i+1] <= sb_s[i];
			end
		end
	end

	// restore sign
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			quo[k] = sg_s[QB][k] ? (FRAC + 2)'(-(FRAC + 2)'(q_s[QB][k]))
			                     : (FRAC + 2)'(q_s[QB][k]);
		end
	end

	assign out_valid = v_s[QB];
	assign out_sb    = sb_s[QB];

endmodule
